// ===== design/rqs_pkg.sv =====
// shared types and constants for the retransmit queue scheduler
// no dependencies; compiled before every other file
`timescale 1ns / 1ps

package rqs_pkg;

	localparam int unsigned SLOTS = 8;
	localparam int unsigned IDX_W = $clog2(SLOTS);

	localparam logic [31:0] URG_GAP_RST   = 32'd100;
	localparam logic [31:0] NORM_GAP_RST  = 32'd1000;
	localparam logic [7:0]  URG_LIMIT_RST = 8'd3;

	localparam logic [1:0] REG_URG_GAP   = 2'd0;
	localparam logic [1:0] REG_NORM_GAP  = 2'd1;
	localparam logic [1:0] REG_URG_LIMIT = 2'd2;

	typedef enum logic [1:0] {
		OP_POLL = 2'd0,
		OP_ENQ  = 2'd1,
		OP_ACK  = 2'd2,
		OP_CLR  = 2'd3
	} op_t;

	typedef struct packed {
		logic [31:0] urg_gap;
		logic [31:0] norm_gap;
		logic [7:0]  urg_limit;
	} cfg_t;

	typedef struct packed {
		logic             valid;
		op_t              op;
		logic [31:0]      now;
		logic [23:0]      id;
		logic             urg;
		logic             send;
		logic [IDX_W-1:0] send_idx;
		logic [23:0]      send_id;
		logic             found;
		logic [IDX_W-1:0] free_idx;
		logic [7:0]       most;
		logic [IDX_W-1:0] evict_idx;
	} tok_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] idx;
		logic [23:0]      id;
		logic             urg;
		logic [31:0]      now;
	} wr_t;

endpackage

// ===== design/rqs_if.sv =====
// command and send channel interfaces of the retransmit queue scheduler
// depends on rqs_pkg
`timescale 1ns / 1ps

interface rqs_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [31:0] now_ms;
	logic [23:0] package_id;
	logic        urgent;

	modport source (output valid, op, now_ms, package_id, urgent, input ready);
	modport sink (input valid, op, now_ms, package_id, urgent, output ready);
endinterface

interface rqs_snd_if;
	logic                    valid;
	logic                    ready;
	logic [rqs_pkg::IDX_W-1:0] slot_index;
	logic [23:0]             sent_id;
	logic                    first_send;
	logic                    last;

	modport source (output valid, slot_index, sent_id, first_send, last, input ready);
	modport sink (input valid, slot_index, sent_id, first_send, last, output ready);
endinterface

// ===== design/retransmit_queue_scheduler_core.sv =====
// top level of the retransmit queue scheduler: config registers, token sequencing
// and send output; depends on rqs_pkg, rqs_if and rqs_cell
`timescale 1ns / 1ps

// Usage
// cmd carries one operation per item (poll, enqueue, acknowledge, clear all).
// sends carries one item per packet send, with last set on the final send of a
// command. Acknowledge and clear give no send items; enqueue gives one.
// An accepted command becomes a token that walks the row of slot cells, one
// cell per cycle while the row is not stalled, from the head register through
// the cells to the tail register; enqueue then writes its chosen slot after the
// walk. A resend is held back until the next resend of the same poll turns up
// or the walk ends, then moves to the output register.
// cmd.ready is low while a command is in flight; the next one is taken as
// soon as it finishes, even while a send item still waits on sends.
// When an item waits on a stalled sends, the token holds until the output frees.
// The user must write configuration over the APB port only while no command is
// in flight; the block does not enforce this. Reset frees every slot and
// restores the register defaults; no clearing pass is needed.

module retransmit_queue_scheduler_core (
	input  logic             clk,
	input  logic             arst_n,
	rqs_cmd_if.sink          cmd,
	rqs_snd_if.source        sends,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [3:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	localparam int unsigned SLOTS = rqs_pkg::SLOTS;
	localparam int unsigned IDX_W = rqs_pkg::IDX_W;

	rqs_pkg::cfg_t     cfg_q;
	rqs_pkg::tok_t     head_q, tail_q;
	rqs_pkg::tok_t     chain [SLOTS+1];
	rqs_pkg::wr_t      wr_q;
	logic              busy_q;
	logic              held_valid_q;
	logic [IDX_W-1:0]  held_idx_q;
	logic [23:0]       held_id_q;
	logic              out_valid_q;
	logic [IDX_W-1:0]  out_idx_q;
	logic [23:0]       out_id_q;
	logic              out_first_q;
	logic              out_last_q;

	logic              accept;
	logic              snd_valid;
	logic [IDX_W-1:0]  snd_idx;
	logic [23:0]       snd_id;
	logic              push;
	logic [IDX_W-1:0]  push_idx;
	logic [23:0]       push_id;
	logic              push_first;
	logic              push_last;
	logic              out_free;
	logic              advance;
	logic [IDX_W-1:0]  enq_slot;
	logic [SLOTS+1:0]  tok_vld;

	// config port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.urg_gap   <= rqs_pkg::URG_GAP_RST;
			cfg_q.norm_gap  <= rqs_pkg::NORM_GAP_RST;
			cfg_q.urg_limit <= rqs_pkg::URG_LIMIT_RST;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[3:2])
				rqs_pkg::REG_URG_GAP:   cfg_q.urg_gap   <= pwdata;
				rqs_pkg::REG_NORM_GAP:  cfg_q.norm_gap  <= pwdata;
				rqs_pkg::REG_URG_LIMIT: cfg_q.urg_limit <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			rqs_pkg::REG_URG_GAP:   prdata = cfg_q.urg_gap;
			rqs_pkg::REG_NORM_GAP:  prdata = cfg_q.norm_gap;
			rqs_pkg::REG_URG_LIMIT: prdata = {24'd0, cfg_q.urg_limit};
			default:                prdata = 32'd0;
		endcase
	end

	// cell row
	assign chain[0] = head_q;

	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		rqs_cell #(
			.INDEX(i)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.advance(advance),
			.tok_in (chain[i]),
			.cfg    (cfg_q),
			.wr     (wr_q),
			.tok_out(chain[i+1])
		);
	end

	always_comb begin
		snd_valid = 1'b0;
		snd_idx   = '0;
		snd_id    = '0;
		for (int i = 1; i <= SLOTS; i++) begin
			if (chain[i].valid && chain[i].send) begin
				snd_valid = 1'b1;
				snd_idx   = snd_idx | chain[i].send_idx;
				snd_id    = snd_id | chain[i].send_id;
			end
		end
	end

	always_comb begin
		tok_vld[0] = head_q.valid;
		for (int i = 1; i <= SLOTS; i++)
			tok_vld[i] = chain[i].valid;
		tok_vld[SLOTS+1] = tail_q.valid;
	end

	// output sequencing
	assign enq_slot = tail_q.found ? tail_q.free_idx : tail_q.evict_idx;

	always_comb begin
		push       = 1'b0;
		push_idx   = held_idx_q;
		push_id    = held_id_q;
		push_first = 1'b0;
		push_last  = 1'b0;
		if (snd_valid && held_valid_q) begin
			push = 1'b1;
		end else if (tail_q.valid) begin
			if (held_valid_q) begin
				push      = 1'b1;
				push_last = 1'b1;
			end else if (tail_q.op == rqs_pkg::OP_ENQ) begin
				push       = 1'b1;
				push_idx   = enq_slot;
				push_id    = tail_q.id;
				push_first = 1'b1;
				push_last  = 1'b1;
			end
		end
	end

	assign out_free = !out_valid_q || sends.ready;
	assign advance  = !push || out_free;
	assign accept   = cmd.valid && cmd.ready;
	assign cmd.ready = !busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q       <= '0;
			tail_q       <= '0;
			busy_q       <= 1'b0;
			wr_q         <= '0;
			held_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			wr_q.en <= advance && tail_q.valid && (tail_q.op == rqs_pkg::OP_ENQ);
			if (accept) begin
				head_q.valid     <= 1'b1;
				head_q.op        <= rqs_pkg::op_t'(cmd.op);
				head_q.now       <= cmd.now_ms;
				head_q.id        <= cmd.package_id;
				head_q.urg       <= cmd.urgent;
				head_q.send      <= 1'b0;
				head_q.send_idx  <= '0;
				head_q.send_id   <= '0;
				head_q.found     <= 1'b0;
				head_q.free_idx  <= '0;
				head_q.most      <= 8'd0;
				head_q.evict_idx <= IDX_W'(SLOTS - 1);
			end else if (advance) begin
				head_q.valid <= 1'b0;
			end
			if (accept)
				busy_q <= 1'b1;
			else if (advance && tail_q.valid && tail_q.op != rqs_pkg::OP_ENQ)
				busy_q <= 1'b0;
			else if (wr_q.en)
				busy_q <= 1'b0;
			if (advance) begin
				tail_q <= chain[SLOTS];
				if (tail_q.valid && tail_q.op == rqs_pkg::OP_ENQ) begin
					wr_q.idx <= enq_slot;
					wr_q.id  <= tail_q.id;
					wr_q.urg <= tail_q.urg;
					wr_q.now <= tail_q.now;
				end
				if (snd_valid)
					held_valid_q <= 1'b1;
				else if (tail_q.valid)
					held_valid_q <= 1'b0;
			end
			if (advance && push)
				out_valid_q <= 1'b1;
			else if (sends.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && snd_valid) begin
			held_idx_q <= snd_idx;
			held_id_q  <= snd_id;
		end
		if (advance && push) begin
			out_idx_q   <= push_idx;
			out_id_q    <= push_id;
			out_first_q <= push_first;
			out_last_q  <= push_last;
		end
	end

	assign sends.valid      = out_valid_q;
	assign sends.slot_index = out_idx_q;
	assign sends.sent_id    = out_id_q;
	assign sends.first_send = out_first_q;
	assign sends.last       = out_last_q;

	// checks
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> ($countones(tok_vld) == 0))
		else $error("token in flight while idle");

	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(tok_vld) <= 1)
		else $error("more than one token in the cell row");

	a_held_busy: assert property (@(posedge clk) disable iff (!arst_n)
		held_valid_q |-> busy_q)
		else $error("held send item outside a command");

	a_write_done: assert property (@(posedge clk) disable iff (!arst_n)
		wr_q.en |=> (!busy_q && !wr_q.en))
		else $error("slot write did not end the command");

endmodule

// ===== design/rqs_cell.sv =====
// one slot of the retransmit table: slot state plus one token stage
// depends on rqs_pkg
`timescale 1ns / 1ps

module rqs_cell #(
	parameter int unsigned INDEX = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          advance,
	input  rqs_pkg::tok_t tok_in,
	input  rqs_pkg::cfg_t cfg,
	input  rqs_pkg::wr_t  wr,
	output rqs_pkg::tok_t tok_out
);

	localparam logic [rqs_pkg::IDX_W-1:0] MY_IDX = rqs_pkg::IDX_W'(INDEX);

	logic          pending_q, pending_n;
	logic          urg_q, urg_n;
	logic [31:0]   last_q, last_n;
	logic [7:0]    cnt_q, cnt_n;
	logic [23:0]   id_q, id_n;
	rqs_pkg::tok_t tok_q, tok_n;
	logic [31:0]   elapsed;
	logic [7:0]    cnt_inc;

	always_comb begin
		pending_n = pending_q;
		urg_n     = urg_q;
		last_n    = last_q;
		cnt_n     = cnt_q;
		id_n      = id_q;
		tok_n          = tok_in;
		tok_n.send     = 1'b0;
		tok_n.send_idx = MY_IDX;
		tok_n.send_id  = id_q;
		elapsed = tok_in.now - last_q;
		cnt_inc = (cnt_q == 8'hFF) ? cnt_q : cnt_q + 8'd1;
		if (tok_in.valid && advance) begin
			unique case (tok_in.op)
				rqs_pkg::OP_POLL: begin
					if (pending_q) begin
						if (urg_q && elapsed > cfg.urg_gap) begin
							tok_n.send = 1'b1;
							last_n     = tok_in.now;
							if (cnt_q >= cfg.urg_limit) begin
								cnt_n = 8'd0;
								urg_n = 1'b0;
							end else begin
								cnt_n = cnt_inc;
							end
						end else if (elapsed > cfg.norm_gap) begin
							tok_n.send = 1'b1;
							last_n     = tok_in.now;
							cnt_n      = cnt_inc;
						end
					end
				end
				rqs_pkg::OP_ENQ: begin
					if (!pending_q && !tok_in.found) begin
						tok_n.found    = 1'b1;
						tok_n.free_idx = MY_IDX;
					end
					if (pending_q && cnt_q > tok_in.most) begin
						tok_n.most      = cnt_q;
						tok_n.evict_idx = MY_IDX;
					end
				end
				rqs_pkg::OP_ACK: begin
					if (pending_q && id_q == tok_in.id)
						pending_n = 1'b0;
				end
				rqs_pkg::OP_CLR: begin
					pending_n = 1'b0;
				end
			endcase
		end
		if (wr.en && wr.idx == MY_IDX) begin
			pending_n = 1'b1;
			urg_n     = wr.urg;
			last_n    = wr.now;
			cnt_n     = 8'd0;
			id_n      = wr.id;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 1'b0;
			urg_q     <= 1'b0;
			tok_q     <= '0;
		end else begin
			pending_q <= pending_n;
			urg_q     <= urg_n;
			if (advance)
				tok_q <= tok_n;
		end
	end

	always_ff @(posedge clk) begin
		last_q <= last_n;
		cnt_q  <= cnt_n;
		id_q   <= id_n;
	end

	assign tok_out = tok_q;

endmodule

// ===== dv/tb_retransmit_queue_scheduler_core.sv =====
// testbench for retransmit_queue_scheduler_core: directed and random commands with a
// slot-table predictor checking every send item; depends on rqs_pkg, rqs_if and the core
`timescale 1ns / 1ps

module tb_retransmit_queue_scheduler_core;

	localparam int unsigned SLOTS        = rqs_pkg::SLOTS;
	localparam int unsigned IDX_W        = rqs_pkg::IDX_W;
	localparam int unsigned MAX_CYCLES   = 1000000;
	localparam int unsigned SETTLE_CYCLES = 2 * (SLOTS + 4);
	localparam logic [1:0]  REG_UNUSED   = 2'd3;

	typedef struct packed {
		logic [IDX_W-1:0] slot;
		logic [23:0]      id;
		logic             first;
		logic             last;
	} send_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	rqs_cmd_if cmd_ch ();
	rqs_snd_if snd_ch ();

	retransmit_queue_scheduler_core i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd_ch),
		.sends   (snd_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// slot table as the block should hold it
	logic          slot_busy    [SLOTS];
	logic          slot_urg     [SLOTS];
	logic [31:0]   slot_sent_at [SLOTS];
	logic [7:0]    slot_tries   [SLOTS];
	logic [23:0]   slot_pkt     [SLOTS];
	rqs_pkg::cfg_t cfg_model;

	send_t       send_q [$];
	logic [23:0] id_pool [$];
	int          errors;
	int unsigned cycle_cnt;
	int unsigned snd_idle_pct;
	int unsigned rcv_stall_pct;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt == MAX_CYCLES) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic void predict_sends(rqs_pkg::op_t op, logic [31:0] t_ms,
			logic [23:0] pkt, logic urg);
		int unsigned i;
		int unsigned victim;
		int unsigned n_sent;
		logic [7:0]  most;
		logic [31:0] elapsed;
		logic        resend;
		send_t       s;
		victim = SLOTS;
		n_sent = 0;
		case (op)
			rqs_pkg::OP_ENQ: begin
				for (i = 0; i < SLOTS; i++) begin
					if (!slot_busy[i] && victim == SLOTS)
						victim = i;
				end
				if (victim == SLOTS) begin
					most = 8'd0;
					victim = SLOTS - 1;
					for (i = 0; i < SLOTS; i++) begin
						if (slot_tries[i] > most) begin
							most = slot_tries[i];
							victim = i;
						end
					end
				end
				slot_busy[victim] = 1'b1;
				slot_urg[victim] = urg;
				slot_sent_at[victim] = t_ms;
				slot_tries[victim] = 8'd0;
				slot_pkt[victim] = pkt;
				s.slot = victim[IDX_W-1:0];
				s.id = pkt;
				s.first = 1'b1;
				s.last = 1'b0;
				send_q.push_back(s);
				n_sent = 1;
			end
			rqs_pkg::OP_POLL: begin
				for (i = 0; i < SLOTS; i++) begin
					if (slot_busy[i]) begin
						elapsed = t_ms - slot_sent_at[i];
						resend = 1'b0;
						if (slot_urg[i] && elapsed > cfg_model.urg_gap) begin
							resend = 1'b1;
							if (slot_tries[i] >= cfg_model.urg_limit) begin
								slot_tries[i] = 8'd0;
								slot_urg[i] = 1'b0;
							end else if (slot_tries[i] != 8'hFF) begin
								slot_tries[i]++;
							end
						end else if (elapsed > cfg_model.norm_gap) begin
							resend = 1'b1;
							if (slot_tries[i] != 8'hFF)
								slot_tries[i]++;
						end
						if (resend) begin
							slot_sent_at[i] = t_ms;
							s.slot = i[IDX_W-1:0];
							s.id = slot_pkt[i];
							s.first = 1'b0;
							s.last = 1'b0;
							send_q.push_back(s);
							n_sent++;
						end
					end
				end
			end
			rqs_pkg::OP_ACK: begin
				for (i = 0; i < SLOTS; i++) begin
					if (slot_busy[i] && slot_pkt[i] == pkt)
						slot_busy[i] = 1'b0;
				end
			end
			default: begin
				for (i = 0; i < SLOTS; i++)
					slot_busy[i] = 1'b0;
			end
		endcase
		if (n_sent > 0)
			send_q[send_q.size() - 1].last = 1'b1;
	endfunction

	function automatic logic [31:0] cfg_readback(logic [1:0] idx);
		case (idx)
			rqs_pkg::REG_URG_GAP:  return cfg_model.urg_gap;
			rqs_pkg::REG_NORM_GAP: return cfg_model.norm_gap;
			default:               return {24'd0, cfg_model.urg_limit};
		endcase
	endfunction

	// every task below is entered and left just after a falling edge
	task automatic send_cmd(rqs_pkg::op_t op, logic [31:0] t_ms, logic [23:0] pkt,
			logic urg);
		while ($urandom_range(99) < snd_idle_pct) begin
			cmd_ch.valid <= 1'b0;
			@(negedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.op <= op;
		cmd_ch.now_ms <= t_ms;
		cmd_ch.package_id <= pkt;
		cmd_ch.urgent <= urg;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
		predict_sends(op, t_ms, pkt, urg);
		@(negedge clk);
	endtask

	task automatic wait_idle();
		cmd_ch.valid <= 1'b0;
		while (send_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk) penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		case (idx)
			rqs_pkg::REG_URG_GAP:   cfg_model.urg_gap = val;
			rqs_pkg::REG_NORM_GAP:  cfg_model.norm_gap = val;
			rqs_pkg::REG_URG_LIMIT: cfg_model.urg_limit = val[7:0];
			default: ;
		endcase
		// read back
		@(negedge clk);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(negedge clk) penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (idx != REG_UNUSED && prdata !== cfg_readback(idx)) begin
			$error("prdata reg %0d expected %h actual %h", idx, cfg_readback(idx), prdata);
			errors++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic write_cfg(logic [31:0] bp, logic [31:0] rp, logic [7:0] bs);
		write_reg(rqs_pkg::REG_URG_GAP, bp);
		write_reg(rqs_pkg::REG_NORM_GAP, rp);
		write_reg(rqs_pkg::REG_URG_LIMIT, {24'd0, bs});
	endtask

	function automatic logic [23:0] pick_id();
		if (id_pool.size() != 0 && $urandom_range(99) < 70)
			return id_pool[$urandom_range(id_pool.size() - 1)];
		return 24'($urandom);
	endfunction

	// fill all slots, then evict with every attempt count at zero
	task automatic test_enqueue_eviction();
		send_cmd(rqs_pkg::OP_ENQ, 32'd0, 24'h000000, 1'b0);
		send_cmd(rqs_pkg::OP_ENQ, 32'hFFFF_FFFF, 24'hFFFFFF, 1'b1);
		send_cmd(rqs_pkg::OP_ENQ, 32'd2, 24'h123456, 1'b0);
		send_cmd(rqs_pkg::OP_ENQ, 32'd3, 24'hABCDEF, 1'b1);
		send_cmd(rqs_pkg::OP_ENQ, 32'd4, 24'h654321, 1'b0);
		send_cmd(rqs_pkg::OP_ENQ, 32'd5, 24'hABCDEF, 1'b0);
		send_cmd(rqs_pkg::OP_ENQ, 32'd6, 24'h00FF00, 1'b1);
		send_cmd(rqs_pkg::OP_ENQ, 32'd7, 24'hFF00FF, 1'b0);
		send_cmd(rqs_pkg::OP_ENQ, 32'd8, 24'h0F0F0F, 1'b1);
		wait_idle();
	endtask

	// exact period boundaries, wrap of the time, urgent burst running out
	task automatic test_poll_periods();
		send_cmd(rqs_pkg::OP_POLL, 32'd100, 24'h000000, 1'b0);
		send_cmd(rqs_pkg::OP_POLL, 32'd104, 24'h000000, 1'b0);
		send_cmd(rqs_pkg::OP_POLL, 32'd200, 24'h000000, 1'b0);
		send_cmd(rqs_pkg::OP_POLL, 32'd205, 24'h000000, 1'b0);
		send_cmd(rqs_pkg::OP_POLL, 32'd306, 24'h000000, 1'b0);
		send_cmd(rqs_pkg::OP_POLL, 32'd1000, 24'h000000, 1'b0);
		send_cmd(rqs_pkg::OP_POLL, 32'd1001, 24'h000000, 1'b0);
		send_cmd(rqs_pkg::OP_POLL, 32'd1500, 24'h000000, 1'b0);
		send_cmd(rqs_pkg::OP_POLL, 32'd2600, 24'h000000, 1'b0);
		wait_idle();
	endtask

	// unknown id, id held by two slots, clear of the whole table
	task automatic test_ack_and_clear();
		send_cmd(rqs_pkg::OP_ACK, 32'd2600, 24'h5A5A5A, 1'b0);
		send_cmd(rqs_pkg::OP_ACK, 32'd2600, 24'hABCDEF, 1'b0);
		send_cmd(rqs_pkg::OP_POLL, 32'd5000, 24'h000000, 1'b0);
		send_cmd(rqs_pkg::OP_ENQ, 32'd5001, 24'h777777, 1'b1);
		send_cmd(rqs_pkg::OP_CLR, 32'd5002, 24'h000000, 1'b0);
		send_cmd(rqs_pkg::OP_POLL, 32'd9000, 24'h000000, 1'b0);
		send_cmd(rqs_pkg::OP_ENQ, 32'd9001, 24'h888888, 1'b0);
		wait_idle();
	endtask

	// burst size zero, zero and full-scale periods, write to an unused address
	task automatic test_burst_extremes();
		write_cfg(32'd0, 32'hFFFF_FFFF, 8'd0);
		write_reg(REG_UNUSED, 32'hFFFF_FFFF);
		send_cmd(rqs_pkg::OP_CLR, 32'd10, 24'h000000, 1'b0);
		send_cmd(rqs_pkg::OP_ENQ, 32'd10, 24'hC0FFEE, 1'b1);
		send_cmd(rqs_pkg::OP_POLL, 32'd10, 24'h000000, 1'b0);
		send_cmd(rqs_pkg::OP_POLL, 32'd11, 24'h000000, 1'b0);
		send_cmd(rqs_pkg::OP_POLL, 32'd12, 24'h000000, 1'b0);
		wait_idle();
		write_cfg(32'hFFFF_FFFF, 32'd0, 8'd255);
		send_cmd(rqs_pkg::OP_ENQ, 32'd20, 24'hBEEF00, 1'b1);
		send_cmd(rqs_pkg::OP_POLL, 32'd21, 24'h000000, 1'b0);
		send_cmd(rqs_pkg::OP_POLL, 32'd21, 24'h000000, 1'b0);
		wait_idle();
	endtask

	task automatic run_traffic(int unsigned n_items, int unsigned step_max,
			logic [31:0] t_start);
		logic [31:0] t_ms;
		logic [23:0] pkt;
		int unsigned pick;
		t_ms = t_start;
		repeat (n_items) begin
			pick = $urandom_range(99);
			if (pick < 40) begin
				t_ms += $urandom_range(step_max);
				send_cmd(rqs_pkg::OP_POLL, t_ms, 24'($urandom), 1'($urandom_range(1)));
			end else if (pick < 70) begin
				pkt = pick_id();
				id_pool.push_back(pkt);
				if (id_pool.size() > 12)
					void'(id_pool.pop_front());
				send_cmd(rqs_pkg::OP_ENQ, t_ms, pkt, 1'($urandom_range(1)));
			end else if (pick < 90) begin
				send_cmd(rqs_pkg::OP_ACK, t_ms, pick_id(), 1'($urandom_range(1)));
			end else if (pick < 94) begin
				send_cmd(rqs_pkg::OP_CLR, t_ms, 24'($urandom), 1'($urandom_range(1)));
			end else begin
				send_cmd(rqs_pkg::op_t'(2'($urandom_range(3))), $urandom, 24'($urandom),
					1'($urandom_range(1)));
			end
		end
		wait_idle();
	endtask

	task automatic test_random_traffic();
		write_cfg(32'd5, 32'd30, 8'd2);
		snd_idle_pct = 0;
		rcv_stall_pct = 0;
		run_traffic(45, 20, 32'd0);

		write_cfg(32'd0, 32'd0, 8'd1);
		snd_idle_pct = 85;
		run_traffic(45, 3, 32'd1000);

		write_cfg(32'd20, 32'hFFFF_FFFF, 8'd255);
		snd_idle_pct = 0;
		rcv_stall_pct = 85;
		run_traffic(45, 40, 32'h8000_0000);

		write_cfg(32'hFFFF_FFFF, 32'd50, 8'd1);
		snd_idle_pct = 14;
		rcv_stall_pct = 14;
		run_traffic(45, 35, 32'h0012_3456);

		write_cfg(rqs_pkg::URG_GAP_RST, rqs_pkg::NORM_GAP_RST, rqs_pkg::URG_LIMIT_RST);
		snd_idle_pct = 0;
		rcv_stall_pct = 0;
		run_traffic(45, 300, 32'hFFFF_FF00);
	endtask

	// receiver side stalls
	initial begin
		forever begin
			@(negedge clk);
			snd_ch.ready <= ($urandom_range(99) >= rcv_stall_pct);
		end
	end

	// compare each send item with the oldest expectation
	initial begin
		send_t exp_send;
		forever begin
			@(posedge clk);
			if (arst_n && snd_ch.valid && snd_ch.ready) begin
				if (send_q.size() == 0) begin
					$error("unexpected send item slot_index %0d sent_id %h",
						snd_ch.slot_index, snd_ch.sent_id);
					errors++;
				end else begin
					exp_send = send_q.pop_front();
					if (snd_ch.slot_index !== exp_send.slot) begin
						$error("slot_index expected %0d actual %0d", exp_send.slot,
							snd_ch.slot_index);
						errors++;
					end
					if (snd_ch.sent_id !== exp_send.id) begin
						$error("sent_id expected %h actual %h", exp_send.id, snd_ch.sent_id);
						errors++;
					end
					if (snd_ch.first_send !== exp_send.first) begin
						$error("first_send expected %b actual %b", exp_send.first,
							snd_ch.first_send);
						errors++;
					end
					if (snd_ch.last !== exp_send.last) begin
						$error("last expected %b actual %b", exp_send.last, snd_ch.last);
						errors++;
					end
				end
			end
		end
	end

	initial begin
		int unsigned i;
		errors = 0;
		cycle_cnt = 0;
		snd_idle_pct = 0;
		rcv_stall_pct = 0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cmd_ch.valid = 1'b0;
		cmd_ch.op = rqs_pkg::OP_POLL;
		cmd_ch.now_ms = '0;
		cmd_ch.package_id = '0;
		cmd_ch.urgent = 1'b0;
		snd_ch.ready = 1'b0;
		cfg_model.urg_gap = rqs_pkg::URG_GAP_RST;
		cfg_model.norm_gap = rqs_pkg::NORM_GAP_RST;
		cfg_model.urg_limit = rqs_pkg::URG_LIMIT_RST;
		for (i = 0; i < SLOTS; i++) begin
			slot_busy[i] = 1'b0;
			slot_urg[i] = 1'b0;
			slot_sent_at[i] = '0;
			slot_tries[i] = '0;
			slot_pkt[i] = '0;
		end
		repeat (6) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		@(negedge clk);

		test_enqueue_eviction();
		test_poll_periods();
		test_ack_and_clear();
		test_burst_extremes();
		test_random_traffic();

		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
